// ----- hw/rtl/urf_pkg.sv -----
`default_nettype none

package urf_pkg;

  // Register map and bit positions
  localparam int NumRegs    = 15;
  localparam int RegIdxW    = 4;
  localparam int DataW      = 32;
  localparam int ByteW      = 8;
  localparam int SpaceW     = 5;

  localparam logic [RegIdxW-1:0] IdxRecCtrl = 4'd2;
  localparam logic [RegIdxW-1:0] IdxDout    = 4'd7;
  localparam logic [RegIdxW-1:0] IdxStatPop = 4'd8;
  localparam logic [RegIdxW-1:0] IdxStat    = 4'd9;
  localparam logic [RegIdxW-1:0] IdxMask    = 4'd11;
  localparam logic [RegIdxW-1:0] IdxAck     = 4'd12;
  localparam logic [RegIdxW-1:0] IdxIntr    = 4'd13;
  localparam logic [RegIdxW-1:0] IdxMasked  = 4'd14;

  localparam int BitDav       = 16;
  localparam int BitTrIdle    = 22;
  localparam int BitTrRdy     = 24;
  localparam int BitRecEnable = 3;
  localparam int BitIntrFifo  = 3;

  localparam logic [DataW-1:0] RecCtrlReset = 32'h0001_0000;
  localparam logic [DataW-1:0] StatusFixed  = (32'd1 << BitTrRdy) | (32'd1 << BitTrIdle);
  localparam logic [DataW-1:0] IntrTxBits   = 32'h0000_0003;

  localparam int FifoDepthDefault = 16;

  typedef enum logic [1:0] {
    CmdRead   = 2'd0,
    CmdWrite  = 2'd1,
    CmdRxByte = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [RegIdxW-1:0] reg_index;
    logic [DataW-1:0]   wdata;
    logic [ByteW-1:0]   rx_byte;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0]  rdata;
    logic              irq_level;
    logic              tx_valid;
    logic [ByteW-1:0]  tx_byte;
    logic [SpaceW-1:0] rx_space;
    logic              rx_dropped;
  } rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/urf_req_if.sv -----
`default_nettype none

interface urf_req_if;
  import urf_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [RegIdxW-1:0] reg_index;
  logic [DataW-1:0]   wdata;
  logic [ByteW-1:0]   rx_byte;

  modport source (output valid, output cmd, output reg_index, output wdata, output rx_byte,
                  input ready);
  modport sink   (input valid, input cmd, input reg_index, input wdata, input rx_byte,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/urf_rsp_if.sv -----
`default_nettype none

interface urf_rsp_if;
  import urf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DataW-1:0]  rdata;
  logic              irq_level;
  logic              tx_valid;
  logic [ByteW-1:0]  tx_byte;
  logic [SpaceW-1:0] rx_space;
  logic              rx_dropped;

  modport source (output valid, output rdata, output irq_level, output tx_valid,
                  output tx_byte, output rx_space, output rx_dropped, input ready);
  modport sink   (input valid, input rdata, input irq_level, input tx_valid,
                  input tx_byte, input rx_space, input rx_dropped, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/uart_register_file_rx_fifo.sv -----
// UART register block with a receive FIFO of FifoDepth bytes.
//
// req_i carries one request per handshake: a bus read, a bus write, or a
// byte arriving from the serial line (cmd selects which). rsp_o returns
// exactly one response per request, in order: read data, the interrupt
// line, a transmit byte strobe for data-out writes, the free FIFO space
// and a drop flag for received bytes that found the receiver disabled or
// the FIFO full.
//
// A request is first captured in the input register, then register file
// and FIFO are updated and the response is registered. Throughput is one
// request per cycle while rsp_o is not stalled; a new request is taken
// while the previous response is still waiting on rsp_o. When the receiver
// stalls, the response register holds and the input register takes one
// more request before req_i.ready drops.
//
// Reset clears the FIFO, the interrupt state and the pointers and loads
// the receive control and status words; the block accepts requests in the
// first cycle after reset is released.
`default_nettype none

module uart_register_file_rx_fifo #(
  parameter int FifoDepth = urf_pkg::FifoDepthDefault
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  urf_req_if.sink    req_i,
  urf_rsp_if.source  rsp_o
);
  import urf_pkg::*;

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam int SpW  = (CntW > SpaceW) ? CntW : SpaceW;
  localparam logic [PtrW-1:0] PtrLast  = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(FifoDepth);
  localparam logic [SpW-1:0]  SpDepth  = SpW'(FifoDepth);
  localparam logic [SpW-1:0]  SpMax    = SpW'((1 << SpaceW) - 1);

  // Handshake and pipeline control
  logic in_v_q, out_v_q;
  logic advance, proc;
  req_t in_q;
  rsp_t out_q, out_d;

  // Architectural state
  logic [DataW-1:0] regs_q [NumRegs];
  logic [DataW-1:0] regs_d [NumRegs];
  logic [ByteW-1:0] mem [FifoDepth];
  logic [FifoDepth-1:0] valid_q;
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic tx_pend_q, tx_pend_d;
  logic irq_q, irq_d;
  logic [ByteW-1:0] head_q;
  logic push, pop;
  logic [SpW-1:0] space_wide;

  assign advance     = !out_v_q || rsp_o.ready;
  assign req_i.ready = !in_v_q || advance;
  assign proc        = in_v_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (req_i.ready) begin
      in_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q <= '{cmd: req_i.cmd, reg_index: req_i.reg_index,
                wdata: req_i.wdata, rx_byte: req_i.rx_byte};
    end
  end

  always_comb begin
    logic [DataW-1:0] value;
    logic [RegIdxW-1:0] idx;
    logic rx_en;

    value     = in_q.wdata;
    idx       = in_q.reg_index;
    rx_en     = regs_q[IdxRecCtrl][BitRecEnable];
    regs_d    = regs_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    fill_d    = fill_q;
    tx_pend_d = tx_pend_q;
    irq_d     = irq_q;
    push      = 1'b0;
    pop       = 1'b0;
    out_d     = '0;

    case (cmd_e'(in_q.cmd))
      CmdRead: begin
        if (idx == IdxStat || idx == IdxStatPop) begin
          out_d.rdata = StatusFixed | {{(DataW-ByteW){1'b0}}, head_q};
          out_d.rdata[BitDav] = (fill_q != '0);
          // pop without refreshing the interrupt state
          pop = (idx == IdxStatPop) && (fill_q != '0);
        end else if (idx < RegIdxW'(NumRegs)) begin
          out_d.rdata = regs_q[idx];
        end
      end
      CmdWrite: begin
        if (idx == IdxDout) begin
          out_d.tx_valid   = 1'b1;
          out_d.tx_byte    = value[ByteW-1:0];
          regs_d[IdxIntr]  = regs_d[IdxIntr] | IntrTxBits;
          tx_pend_d        = 1'b1;
          regs_d[IdxDout]  = value;
        end else if (idx == IdxAck) begin
          // spare bit 0 once while a transmit is pending
          if (tx_pend_q) begin
            value[0]  = 1'b0;
            tx_pend_d = 1'b0;
          end
          regs_d[IdxAck]  = value;
          regs_d[IdxIntr] = regs_d[IdxIntr] & ~value;
        end else if (idx < RegIdxW'(NumRegs)) begin
          regs_d[idx] = value;
        end
        regs_d[IdxIntr][BitIntrFifo] = (fill_q != '0);
        regs_d[IdxMasked] = regs_d[IdxIntr] & regs_d[IdxMask];
        irq_d = (regs_d[IdxMasked] != '0);
      end
      CmdRxByte: begin
        if (!rx_en || fill_q >= CntFull) begin
          out_d.rx_dropped = 1'b1;
        end else begin
          push = 1'b1;
          regs_d[IdxIntr][BitIntrFifo] = 1'b1;
          regs_d[IdxMasked] = regs_d[IdxIntr] & regs_d[IdxMask];
          irq_d = (regs_d[IdxMasked] != '0);
        end
      end
      default: begin
      end
    endcase

    if (!proc) begin
      push = 1'b0;
      pop  = 1'b0;
    end
    if (push) begin
      wp_d   = (wp_q == PtrLast) ? '0 : wp_q + 1'b1;
      fill_d = fill_q + 1'b1;
    end
    if (pop) begin
      rp_d   = (rp_q == PtrLast) ? '0 : rp_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end

    space_wide = '0;
    if (regs_d[IdxRecCtrl][BitRecEnable] && fill_d < CntFull) begin
      space_wide = SpDepth - SpW'(fill_d);
    end
    out_d.rx_space  = (space_wide > SpMax) ? SpaceW'(SpMax) : space_wide[SpaceW-1:0];
    out_d.irq_level = irq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= '0;
      end
      regs_q[IdxRecCtrl] <= RecCtrlReset;
      regs_q[IdxStatPop] <= StatusFixed;
      wp_q      <= '0;
      rp_q      <= '0;
      fill_q    <= '0;
      tx_pend_q <= 1'b0;
      irq_q     <= 1'b0;
      valid_q   <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (proc) begin
        regs_q    <= regs_d;
        wp_q      <= wp_d;
        rp_q      <= rp_d;
        fill_q    <= fill_d;
        tx_pend_q <= tx_pend_d;
        irq_q     <= irq_d;
      end
      if (push) begin
        valid_q[wp_q] <= 1'b1;
      end
      if (advance) begin
        out_v_q <= in_v_q;
      end
    end
  end

  // FIFO storage; head_q prefetches the entry at the next read pointer
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wp_q] <= in_q.rx_byte;
    end
    if (push && wp_q == rp_d) begin
      head_q <= in_q.rx_byte;
    end else if (valid_q[rp_d]) begin
      head_q <= mem[rp_d];
    end else begin
      head_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid      = out_v_q;
  assign rsp_o.rdata      = out_q.rdata;
  assign rsp_o.irq_level  = out_q.irq_level;
  assign rsp_o.tx_valid   = out_q.tx_valid;
  assign rsp_o.tx_byte    = out_q.tx_byte;
  assign rsp_o.rx_space   = out_q.rx_space;
  assign rsp_o.rx_dropped = out_q.rx_dropped;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntFull)
    else $error("FIFO fill count above depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> fill_q != CntFull)
    else $error("push into a full FIFO");

  a_intr_fifo_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.cmd == CmdWrite |=> regs_q[IdxIntr][BitIntrFifo] == (fill_q != '0))
    else $error("interrupt FIFO bit out of step with occupancy");

  a_irq_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_q.cmd == CmdWrite |=>
      regs_q[IdxMasked] == (regs_q[IdxIntr] & regs_q[IdxMask]) &&
      irq_q == (regs_q[IdxMasked] != '0))
    else $error("interrupt line not refreshed after write");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import urf_pkg::*;

  localparam int          FifoDepth   = FifoDepthDefault;
  localparam int          ItemTarget  = 1870;
  localparam int          CalmItems   = 200;
  localparam int          CycleLimit  = 500000;
  localparam int          DrainCycles = 8;
  localparam logic [1:0]  CmdNone     = 2'd3;
  localparam logic [RegIdxW-1:0] IdxTxCtrl   = 4'd0;
  localparam logic [RegIdxW-1:0] IdxUnmapped = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  urf_req_if req_if ();
  urf_rsp_if rsp_if ();

  uart_register_file_rx_fifo #(
    .FifoDepth(FifoDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the block's state
  logic [DataW-1:0] shadow_regs [NumRegs];
  logic [ByteW-1:0] shadow_fifo [FifoDepth];
  int               shadow_wr_pos;
  int               shadow_fill;
  bit               shadow_tx_pend;
  bit               shadow_irq;

  rsp_t expected_rsp_q [$];
  rsp_t want_rsp;
  int   mismatch_cnt = 0;
  int   req_cnt = 0;
  int   cycle_cnt = 0;
  int   stall_left = 0;
  bit   req_idle_on = 1'b1;
  bit   rsp_stall_on = 1'b1;

  function automatic void shadow_reset();
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_fifo[i]) shadow_fifo[i] = '0;
    shadow_regs[IdxRecCtrl] = RecCtrlReset;
    shadow_regs[IdxStatPop] = StatusFixed;
    shadow_wr_pos  = 0;
    shadow_fill    = 0;
    shadow_tx_pend = 1'b0;
    shadow_irq     = 1'b0;
  endfunction

  function automatic void refresh_irq_state();
    shadow_regs[IdxIntr][BitIntrFifo] = (shadow_fill != 0);
    shadow_regs[IdxMasked] = shadow_regs[IdxIntr] & shadow_regs[IdxMask];
    shadow_irq = |shadow_regs[IdxMasked];
  endfunction

  function automatic rsp_t predict_response(logic [1:0] cmd, logic [RegIdxW-1:0] idx,
                                            logic [DataW-1:0] wdata, logic [ByteW-1:0] rxb);
    rsp_t             rsp;
    logic [DataW-1:0] val;
    bit               rx_on;
    rsp = '0;
    val = wdata;
    case (cmd)
      CmdRead: begin
        if (idx == IdxStat || idx == IdxStatPop) begin
          // Oldest entry, or the stale one at the write pointer when empty
          rsp.rdata = {24'd0, shadow_fifo[(shadow_wr_pos + FifoDepth - shadow_fill) % FifoDepth]}
                      | StatusFixed;
          rsp.rdata[BitDav] = (shadow_fill != 0);
          // Pop without refreshing the interrupt state
          if (idx == IdxStatPop && shadow_fill != 0) shadow_fill--;
        end else if (idx < NumRegs) begin
          rsp.rdata = shadow_regs[idx];
        end
      end
      CmdWrite: begin
        if (idx == IdxDout) begin
          rsp.tx_valid = 1'b1;
          rsp.tx_byte  = wdata[ByteW-1:0];
          shadow_regs[IdxIntr] |= IntrTxBits;
          shadow_tx_pend = 1'b1;
          shadow_regs[idx] = wdata;
        end else if (idx == IdxAck) begin
          // Spare bit 0 once while a transmit is pending
          if (shadow_tx_pend) begin
            val[0] = 1'b0;
            shadow_tx_pend = 1'b0;
          end
          shadow_regs[idx] = val;
          shadow_regs[IdxIntr] &= ~val;
        end else if (idx < NumRegs) begin
          shadow_regs[idx] = wdata;
        end
        refresh_irq_state();
      end
      CmdRxByte: begin
        rx_on = shadow_regs[IdxRecCtrl][BitRecEnable];
        if (!rx_on || shadow_fill >= FifoDepth) begin
          rsp.rx_dropped = 1'b1;
        end else begin
          shadow_fifo[shadow_wr_pos] = rxb;
          shadow_wr_pos = (shadow_wr_pos + 1) % FifoDepth;
          shadow_fill++;
          refresh_irq_state();
        end
      end
      default: ;
    endcase
    rx_on = shadow_regs[IdxRecCtrl][BitRecEnable];
    if (rx_on && shadow_fill < FifoDepth) rsp.rx_space = SpaceW'(FifoDepth - shadow_fill);
    rsp.irq_level = shadow_irq;
    return rsp;
  endfunction

  // Predict at each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) begin
      expected_rsp_q.push_back(predict_response(req_if.cmd, req_if.reg_index,
                                                req_if.wdata, req_if.rx_byte));
    end
  end

  task automatic check_field(string field, logic [DataW-1:0] exp_v, logic [DataW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        $error("response: expected none, actual rdata 0x%0h", rsp_if.rdata);
        mismatch_cnt++;
      end else begin
        want_rsp = expected_rsp_q.pop_front();
        check_field("rdata", want_rsp.rdata, rsp_if.rdata);
        check_field("irq_level", want_rsp.irq_level, rsp_if.irq_level);
        check_field("tx_valid", want_rsp.tx_valid, rsp_if.tx_valid);
        check_field("tx_byte", want_rsp.tx_byte, rsp_if.tx_byte);
        check_field("rx_space", want_rsp.rx_space, rsp_if.rx_space);
        check_field("rx_dropped", want_rsp.rx_dropped, rsp_if.rx_dropped);
      end
    end
  end

  // Response side: stall in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (rsp_stall_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] cmd, logic [RegIdxW-1:0] idx,
                          logic [DataW-1:0] wdata, logic [ByteW-1:0] rxb);
    if (req_idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.cmd       <= cmd;
    req_if.reg_index <= idx;
    req_if.wdata     <= wdata;
    req_if.rx_byte   <= rxb;
    do @(posedge clk_i); while (!req_if.ready);
    if (cmd != CmdNone) req_cnt++;
  endtask

  task automatic bus_read(logic [RegIdxW-1:0] idx);
    send_req(CmdRead, idx, $urandom(), 8'($urandom()));
  endtask

  task automatic bus_write(logic [RegIdxW-1:0] idx, logic [DataW-1:0] wdata);
    send_req(CmdWrite, idx, wdata, 8'($urandom()));
  endtask

  task automatic rx_push(logic [ByteW-1:0] rxb);
    send_req(CmdRxByte, 4'($urandom()), $urandom(), rxb);
  endtask

  task automatic test_reset_state();
    bus_read(IdxRecCtrl);
    bus_read(IdxStat);
    bus_read(IdxStatPop);
    bus_read(IdxIntr);
    bus_read(IdxUnmapped);
  endtask

  task automatic test_rx_disabled_drop();
    rx_push(8'hFF);
  endtask

  task automatic test_plain_reg_extremes();
    bus_write(IdxTxCtrl, '1);
    bus_read(IdxTxCtrl);
    bus_write(IdxTxCtrl, '0);
  endtask

  task automatic test_tx_and_ack();
    bus_write(IdxMask, '1);
    bus_write(IdxDout, 32'hFFFF_FFA5);
    bus_write(IdxAck, 32'h1);
    bus_write(IdxAck, '1);
  endtask

  task automatic test_rx_fifo_pop();
    bus_write(IdxRecCtrl, 32'd1 << BitRecEnable);
    rx_push(8'hFF);
    rx_push(8'h00);
    bus_read(IdxStat);
    repeat (3) bus_read(IdxStatPop);
  endtask

  task automatic test_unmapped_and_idle_cmd();
    bus_write(IdxUnmapped, '1);
    send_req(CmdNone, IdxUnmapped, '1, '1);
  endtask

  task automatic test_random_traffic();
    int unsigned n;
    int unsigned kind;
    while (req_cnt < ItemTarget) begin
      if (req_cnt > ItemTarget - CalmItems) begin
        req_idle_on  = 1'b0;
        rsp_stall_on = 1'b0;
      end else begin
        req_idle_on  = $urandom_range(0, 3) != 0;
        rsp_stall_on = $urandom_range(0, 3) != 0;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // Fill then drain, sometimes past full
        bus_write(IdxRecCtrl, $urandom() | (32'd1 << BitRecEnable));
        n = $urandom_range(1, 20);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) bus_read(IdxStat);
          rx_push(8'($urandom()));
        end
        n = $urandom_range(1, 20);
        repeat (n) bus_read($urandom_range(0, 3) == 0 ? IdxStat : IdxStatPop);
      end else if (kind <= 5) begin
        bus_write(IdxMask, $urandom());
        bus_write(IdxDout, $urandom());
        if ($urandom_range(0, 1) == 0) bus_read(IdxIntr);
        bus_read(IdxMasked);
        bus_write(IdxAck, $urandom_range(0, 1) ? IntrTxBits : $urandom());
      end else if (kind == 6) begin
        bus_write(IdxRecCtrl, $urandom() & ~(32'd1 << BitRecEnable));
        repeat ($urandom_range(1, 4)) rx_push(8'($urandom()));
        bus_read(IdxStatPop);
      end else begin
        repeat ($urandom_range(1, 8))
          send_req(2'($urandom()), 4'($urandom()), $urandom(), 8'($urandom()));
      end
    end
  endtask

  initial begin
    req_if.valid     <= 1'b0;
    req_if.cmd       <= CmdRead;
    req_if.reg_index <= '0;
    req_if.wdata     <= '0;
    req_if.rx_byte   <= '0;
    shadow_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_rx_disabled_drop();
    test_plain_reg_extremes();
    test_tx_and_ack();
    test_rx_fifo_pop();
    test_unmapped_and_idle_cmd();
    test_random_traffic();

    req_if.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_rsp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
